### rtl/core/bba_pkg.sv
`default_nettype none

package bba_pkg;

  // Defaults for the top-level parameters.
  localparam int DEF_MIN_BLOCK_LOG2 = 12;
  localparam int DEF_MAX_ORDER      = 10;

  // Field widths fixed by the stream format.
  localparam int FIELD_W = 23;
  localparam int ORD_W   = 4;
  localparam int META_W  = 6;
  // Scan position in minimum-block units, wide enough for a start plus any span
  // that a 4-bit order can encode.
  localparam int WIDE_W  = 18;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_TOO_LARGE   = 3'd1,
    ST_NO_MEMORY   = 3'd2,
    ST_BAD_ADDRESS = 3'd3,
    ST_IGNORED     = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_ORDER,
    S_A_RD,
    S_A_EV,
    S_A_SPLIT,
    S_F_RD,
    S_F_CHK,
    S_F_MRG,
    S_F_BUD,
    S_F_WLO,
    S_DONE
  } state_t;

  // Metadata entry: order in bits 5..2, left buddy in bit 1, allocated in bit 0.
  typedef struct packed {
    logic [ORD_W-1:0] order;
    logic             left;
    logic             alloc;
  } meta_t;

  function automatic meta_t make_entry(input logic [ORD_W-1:0] ord, input logic left);
    meta_t e;
    e.order = ord;
    e.left  = left;
    e.alloc = 1'b0;
    return e;
  endfunction

endpackage

`default_nettype wire

### rtl/core/bba_ram.sv
`default_nettype none

module bba_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### rtl/core/buddy_block_allocator_unit.sv
`default_nettype none

// Buddy allocator over a region of 2^(MIN_BLOCK_LOG2 + MAX_ORDER) bytes, built from
// minimum blocks of 2^MIN_BLOCK_LOG2 bytes, with one 6-bit metadata entry per minimum
// block held in a RAM with one read port, one write port and registered read. Each
// input beat is one command (tuser 0 allocate, 1 free) and yields exactly one result
// beat with a status and, for a successful allocate, the block start plus one. The
// block takes one command at a time and drops in_tready until the result is handed to
// the output register. An allocate first finds the required order from the request in
// minimum blocks, then scans blocks first fit in address order, reading each block and
// splitting a larger free block, which is then read again at its new order; a free reads
// and checks its block, then merges while the buddy is inside the region and free at the
// same order. A command that is rejected at once goes straight to the result. Every step
// is bounded by the metadata RAM, with its registered read, and one shared position adder.
// After reset the metadata RAM is swept one entry per cycle, so the block accepts no
// command until all 2^MAX_ORDER entries (1024 by default) are written.
module buddy_block_allocator_unit #(
  parameter int MIN_BLOCK_LOG2 = bba_pkg::DEF_MIN_BLOCK_LOG2,
  parameter int MAX_ORDER      = bba_pkg::DEF_MAX_ORDER
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,   // request_bytes [22:0], free_offset [45:23], zero pad
  input  wire logic        in_tuser,   // command
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [31:0] out_tdata   // status [2:0], block_offset [25:3], zero pad
);

  import bba_pkg::*;

  localparam int          SLOT_W      = MAX_ORDER;
  localparam int          ENTRY_COUNT = 1 << MAX_ORDER;
  localparam int          REGION_LOG2 = MIN_BLOCK_LOG2 + MAX_ORDER;
  localparam logic [31:0] REGION      = 32'(1) << REGION_LOG2;
  localparam logic [31:0] MIN_MASK    = (32'(1) << MIN_BLOCK_LOG2) - 32'd1;
  localparam logic [WIDE_W-1:0] ENTRY_END = WIDE_W'(ENTRY_COUNT);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(ENTRY_COUNT - 1);

  state_t              state_r, state_nxt;
  logic [SLOT_W-1:0]   clr_r;
  logic [WIDE_W-1:0]   pos_r;
  logic [WIDE_W-1:0]   oth_r;
  meta_t               cur_r;
  logic [ORD_W-1:0]    want_r;
  logic [ORD_W-1:0]    half_r;
  logic [FIELD_W-1:0]  scan_r;
  status_t             res_status_r;
  logic [FIELD_W-1:0]  res_off_r;
  logic                out_valid_r;
  status_t             out_status_r;
  logic [FIELD_W-1:0]  out_off_r;

  logic                mem_we;
  logic [SLOT_W-1:0]   mem_waddr;
  meta_t               mem_wdata;
  logic [SLOT_W-1:0]   mem_raddr;
  logic [META_W-1:0]   mem_rdata;
  meta_t               rd_ent;

  logic                in_fire;
  logic [FIELD_W-1:0]  in_req;
  logic [FIELD_W-1:0]  in_off;
  logic [31:0]         req_ext;
  logic [31:0]         off_ext;
  logic [31:0]         free_pos;
  logic                req_big;
  logic                off_bad;
  logic                off_misaligned;

  // Shared position adder.
  logic [ORD_W-1:0]    add_ord;
  logic                add_sub;
  logic [WIDE_W-1:0]   add_span;
  logic [WIDE_W-1:0]   add_y;

  logic                ev_skip;
  logic                ev_hit;
  logic                mrg_stop;
  logic                bud_stop;
  logic [WIDE_W-1:0]   lo_pos;
  logic [WIDE_W-1:0]   hi_pos;
  logic [WIDE_W-1:0]   align_mask;
  meta_t               merged;
  logic [31:0]         alloc_off;

  logic                fin_go;
  status_t             fin_status;
  logic [FIELD_W-1:0]  fin_off;

  bba_ram #(
    .WIDTH(META_W),
    .DEPTH(ENTRY_COUNT)
  ) u_meta (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  assign rd_ent   = meta_t'(mem_rdata);
  assign in_req   = in_tdata[FIELD_W-1:0];
  assign in_off   = in_tdata[2*FIELD_W-1:FIELD_W];
  assign in_tready = (state_r == S_IDLE);
  assign in_fire  = in_tvalid && in_tready;

  assign req_ext        = 32'(in_req);
  assign off_ext        = 32'(in_off);
  assign free_pos       = off_ext - 32'd1;
  assign req_big        = (req_ext >= REGION);
  assign off_bad        = (off_ext == 32'd0) || (off_ext > REGION);
  assign off_misaligned = ((free_pos & MIN_MASK) != 32'd0);

  always_comb begin
    add_ord = rd_ent.order;
    add_sub = 1'b0;
    case (state_r)
      S_A_SPLIT: add_ord = half_r;
      S_F_MRG: begin
        add_ord = cur_r.order;
        add_sub = !cur_r.left;
      end
      default: add_ord = rd_ent.order;
    endcase
  end

  assign add_span = WIDE_W'(1) << add_ord;
  assign add_y    = add_sub ? (pos_r - add_span) : (pos_r + add_span);

  assign ev_skip  = rd_ent.alloc || (rd_ent.order < want_r);
  assign ev_hit   = (rd_ent.order == want_r);
  // A left block stops at the region end, a right block at the region start.
  assign mrg_stop = cur_r.left ? (add_y >= ENTRY_END) : (pos_r < add_span);
  assign bud_stop = rd_ent.alloc || (rd_ent.order != cur_r.order);

  assign lo_pos     = cur_r.left ? pos_r : oth_r;
  assign hi_pos     = cur_r.left ? oth_r : pos_r;
  assign align_mask = ~({WIDE_W{1'b1}} << (cur_r.order + ORD_W'(2)));
  assign merged     = make_entry(cur_r.order + ORD_W'(1), (lo_pos & align_mask) == '0);
  assign alloc_off  = (32'(pos_r) << MIN_BLOCK_LOG2) | 32'd1;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (clr_r == LAST_SLOT) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          if (cmd_t'(in_tuser) == CMD_ALLOC) begin
            state_nxt = req_big ? S_DONE : S_ORDER;
          end else if (off_bad || off_misaligned) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_F_RD;
          end
        end
      end
      S_ORDER: begin
        if (scan_r == '0) begin
          state_nxt = S_A_RD;
        end
      end
      S_A_RD:    state_nxt = (pos_r >= ENTRY_END) ? S_DONE : S_A_EV;
      S_A_EV: begin
        if (ev_skip) begin
          state_nxt = S_A_RD;
        end else if (ev_hit) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_A_SPLIT;
        end
      end
      S_A_SPLIT: state_nxt = S_A_RD;
      S_F_RD:    state_nxt = S_F_CHK;
      S_F_CHK:   state_nxt = rd_ent.alloc ? S_F_MRG : S_DONE;
      S_F_MRG:   state_nxt = mrg_stop ? S_DONE : S_F_BUD;
      S_F_BUD:   state_nxt = bud_stop ? S_DONE : S_F_WLO;
      S_F_WLO:   state_nxt = S_F_MRG;
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = S_IDLE;
        end
      end
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    mem_we     = 1'b0;
    mem_waddr  = pos_r[SLOT_W-1:0];
    mem_wdata  = rd_ent;
    mem_raddr  = pos_r[SLOT_W-1:0];
    fin_go     = 1'b0;
    fin_status = ST_OK;
    fin_off    = '0;
    case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = (clr_r == '0) ? make_entry(ORD_W'(MAX_ORDER), 1'b1) : meta_t'('0);
      end
      S_IDLE: begin
        if (in_fire) begin
          if (cmd_t'(in_tuser) == CMD_ALLOC) begin
            fin_go     = req_big;
            fin_status = ST_TOO_LARGE;
          end else if (off_bad) begin
            fin_go     = 1'b1;
            fin_status = ST_BAD_ADDRESS;
          end else begin
            fin_go     = off_misaligned;
            fin_status = ST_IGNORED;
          end
        end
      end
      S_A_RD: begin
        fin_go     = (pos_r >= ENTRY_END);
        fin_status = ST_NO_MEMORY;
      end
      S_A_EV: begin
        if (!ev_skip) begin
          mem_we = 1'b1;
          if (ev_hit) begin
            mem_wdata.alloc = 1'b1;
            fin_go          = 1'b1;
            fin_off         = alloc_off[FIELD_W-1:0];
          end else begin
            mem_wdata = make_entry(rd_ent.order - ORD_W'(1), 1'b1);
          end
        end
      end
      S_A_SPLIT: begin
        mem_we    = 1'b1;
        mem_waddr = add_y[SLOT_W-1:0];
        mem_wdata = make_entry(half_r, 1'b0);
      end
      S_F_CHK: begin
        if (rd_ent.alloc) begin
          mem_we          = 1'b1;
          mem_wdata.alloc = 1'b0;
        end else begin
          fin_go     = 1'b1;
          fin_status = ST_IGNORED;
        end
      end
      S_F_MRG: begin
        mem_raddr = add_y[SLOT_W-1:0];
        fin_go    = mrg_stop;
      end
      S_F_BUD: begin
        if (bud_stop) begin
          fin_go = 1'b1;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = hi_pos[SLOT_W-1:0];
          mem_wdata = '0;
        end
      end
      S_F_WLO: begin
        mem_we    = 1'b1;
        mem_waddr = lo_pos[SLOT_W-1:0];
        mem_wdata = merged;
      end
      default: mem_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) begin
        clr_r <= clr_r + SLOT_W'(1);
      end
      if (state_r == S_DONE && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      res_status_r <= fin_status;
      res_off_r    <= fin_off;
    end
    if (state_r == S_DONE && (!out_valid_r || out_tready)) begin
      out_status_r <= res_status_r;
      out_off_r    <= res_off_r;
    end
    case (state_r)
      S_IDLE: begin
        scan_r <= FIELD_W'(in_req >> MIN_BLOCK_LOG2);
        want_r <= '0;
        pos_r  <= WIDE_W'(free_pos >> MIN_BLOCK_LOG2);
      end
      S_ORDER: begin
        // Required order is the bit length of the request in minimum blocks.
        if (scan_r == '0) begin
          pos_r <= '0;
        end else begin
          scan_r <= scan_r >> 1;
          want_r <= want_r + ORD_W'(1);
        end
      end
      S_A_EV: begin
        if (ev_skip) begin
          pos_r <= add_y;
        end
        half_r <= rd_ent.order - ORD_W'(1);
      end
      S_F_CHK: cur_r <= make_entry(rd_ent.order, rd_ent.left);
      S_F_MRG: oth_r <= add_y;
      S_F_WLO: begin
        cur_r <= merged;
        pos_r <= lo_pos;
      end
      default: oth_r <= oth_r;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_off_r, out_status_r};

endmodule

`default_nettype wire

### tb/tb_buddy_block_allocator_unit.sv
`default_nettype none

module tb_buddy_block_allocator_unit;
  import bba_pkg::*;

  localparam int BLOCK_LOG2   = DEF_MIN_BLOCK_LOG2;
  localparam int UNITS        = 1 << DEF_MAX_ORDER;
  localparam int BLOCK_BYTES  = 1 << BLOCK_LOG2;
  localparam int REGION_BYTES = 1 << (DEF_MIN_BLOCK_LOG2 + DEF_MAX_ORDER);
  localparam int RANDOM_ITEMS = 1530;
  localparam int QUIET_ITEMS  = 250;
  localparam int DRAIN_CYCLES = 100;

  typedef struct packed {
    status_t           status;
    logic [FIELD_W-1:0] offset;
  } outcome_t;

  typedef struct {
    cmd_t               cmd;
    logic [FIELD_W-1:0] req;
    logic [FIELD_W-1:0] off;
    bit                 fixed;
    status_t            status;
    logic [FIELD_W-1:0] boff;
  } step_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b1;
  logic [31:0] out_tdata;

  meta_t    heap_meta [UNITS];
  int       live_offsets [$];
  outcome_t pending_results [$];
  outcome_t oldest;
  int       mismatch_count = 0;
  int       hold_left = 0;
  bit       quiet = 1'b0;

  // Rows marked fixed carry a result that follows from the state after reset and the rows
  // before them; the others are checked against the predictor.
  step_row_t directed_steps [24] = '{
    '{CMD_ALLOC, 23'd0,       23'd0,       1'b1, ST_OK,          23'd1},
    '{CMD_ALLOC, 23'd4194304, 23'd0,       1'b1, ST_TOO_LARGE,   23'd0},
    '{CMD_ALLOC, 23'd4194303, 23'd0,       1'b1, ST_NO_MEMORY,   23'd0},
    '{CMD_FREE,  23'd0,       23'd0,       1'b1, ST_BAD_ADDRESS, 23'd0},
    '{CMD_FREE,  23'd0,       23'd4194305, 1'b1, ST_BAD_ADDRESS, 23'd0},
    '{CMD_FREE,  23'd0,       23'd4194304, 1'b1, ST_IGNORED,     23'd0},
    '{CMD_FREE,  23'd0,       23'd2,       1'b1, ST_IGNORED,     23'd0},
    '{CMD_FREE,  23'd0,       23'd1,       1'b1, ST_OK,          23'd0},
    '{CMD_FREE,  23'd0,       23'd1,       1'b1, ST_IGNORED,     23'd0},
    '{CMD_ALLOC, 23'd4194303, 23'd0,       1'b1, ST_OK,          23'd1},
    '{CMD_ALLOC, 23'd1,       23'd0,       1'b1, ST_NO_MEMORY,   23'd0},
    '{CMD_FREE,  23'd0,       23'd1,       1'b1, ST_OK,          23'd0},
    '{CMD_ALLOC, 23'd4095,    23'd0,       1'b0, ST_OK,          23'd0},
    '{CMD_ALLOC, 23'd4096,    23'd0,       1'b0, ST_OK,          23'd0},
    '{CMD_ALLOC, 23'd2097152, 23'd0,       1'b0, ST_OK,          23'd0},
    '{CMD_ALLOC, 23'd2097151, 23'd0,       1'b0, ST_OK,          23'd0},
    '{CMD_FREE,  23'd0,       23'd4097,    1'b0, ST_OK,          23'd0},
    '{CMD_ALLOC, 23'd12288,   23'd0,       1'b0, ST_OK,          23'd0},
    '{CMD_FREE,  23'd0,       23'd8193,    1'b0, ST_OK,          23'd0},
    '{CMD_FREE,  23'd0,       23'd1,       1'b0, ST_OK,          23'd0},
    '{CMD_ALLOC, 23'd8388607, 23'd0,       1'b1, ST_TOO_LARGE,   23'd0},
    '{CMD_FREE,  23'd0,       23'd8388607, 1'b1, ST_BAD_ADDRESS, 23'd0},
    '{CMD_FREE,  23'd0,       23'd2097153, 1'b0, ST_OK,          23'd0},
    '{CMD_ALLOC, 23'd1048575, 23'd0,       1'b0, ST_OK,          23'd0}
  };

  buddy_block_allocator_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic meta_t fresh_entry(input int ord, input bit left);
    meta_t e;
    e.order = ord[ORD_W-1:0];
    e.left  = left;
    e.alloc = 1'b0;
    return e;
  endfunction

  function automatic int need_order(input logic [FIELD_W-1:0] bytes);
    int lg;
    int b;
    lg = 0;
    b  = int'(bytes);
    if (b < BLOCK_BYTES) return 0;
    while (b >= 2) begin
      lg++;
      b = b >> 1;
    end
    return lg - BLOCK_LOG2 + 1;
  endfunction

  function automatic void clear_heap();
    foreach (heap_meta[i]) heap_meta[i] = '0;
    heap_meta[0] = fresh_entry(DEF_MAX_ORDER, 1'b1);
  endfunction

  // First-fit scan in address order, splitting the first large enough free block.
  function automatic outcome_t predict_alloc(input logic [FIELD_W-1:0] bytes);
    outcome_t r;
    int pos;
    int want;
    int ord;
    r.status = ST_NO_MEMORY;
    r.offset = '0;
    if (bytes >= REGION_BYTES) begin
      r.status = ST_TOO_LARGE;
      return r;
    end
    want = need_order(bytes);
    pos  = 0;
    while (pos < UNITS) begin
      ord = int'(heap_meta[pos].order);
      if (heap_meta[pos].alloc || ord < want) begin
        pos += 1 << ord;
      end else if (ord == want) begin
        heap_meta[pos].alloc = 1'b1;
        r.status = ST_OK;
        r.offset = FIELD_W'((pos << BLOCK_LOG2) + 1);
        return r;
      end else begin
        heap_meta[pos] = fresh_entry(ord - 1, 1'b1);
        heap_meta[(pos + (1 << (ord - 1))) % UNITS] = fresh_entry(ord - 1, 1'b0);
      end
    end
    return r;
  endfunction

  function automatic outcome_t predict_free(input logic [FIELD_W-1:0] offset);
    outcome_t r;
    int base;
    int pos;
    int ord;
    int sz;
    int lo;
    int hi;
    int other;
    r.status = ST_OK;
    r.offset = '0;
    if (offset == 0 || offset > REGION_BYTES) begin
      r.status = ST_BAD_ADDRESS;
      return r;
    end
    base = int'(offset) - 1;
    if ((base % BLOCK_BYTES) != 0 || !heap_meta[base >> BLOCK_LOG2].alloc) begin
      r.status = ST_IGNORED;
      return r;
    end
    pos = base >> BLOCK_LOG2;
    heap_meta[pos].alloc = 1'b0;
    while (1'b1) begin
      ord = int'(heap_meta[pos].order);
      sz  = 1 << ord;
      if (heap_meta[pos].left) begin
        if (pos + sz >= UNITS) break;
        lo = pos;
        hi = pos + sz;
      end else begin
        if (pos < sz) break;
        lo = pos - sz;
        hi = pos;
      end
      other = (lo == pos) ? hi : lo;
      if (heap_meta[other % UNITS].alloc || heap_meta[other % UNITS].order != ord) break;
      heap_meta[hi % UNITS] = '0;
      // The merged block is a left buddy when aligned to twice its new size.
      heap_meta[lo % UNITS] = fresh_entry(ord + 1, (lo % (1 << (ord + 2))) == 0);
      pos = lo;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("mismatch: %s", msg);
  endtask

  // Holds one beat on the input until it is taken, then updates the prediction.
  task automatic issue_command(input cmd_t cmd, input logic [FIELD_W-1:0] req,
                               input logic [FIELD_W-1:0] off, input bit fixed,
                               input outcome_t typed);
    outcome_t r;
    int idx [$];
    in_tuser  <= cmd;
    in_tdata  <= {2'b00, off, req};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (cmd == CMD_ALLOC) begin
      r = predict_alloc(req);
      if (r.status == ST_OK) live_offsets.push_back(int'(r.offset));
    end else begin
      r = predict_free(off);
      if (r.status == ST_OK) begin
        idx = live_offsets.find_first_index(x) with (x == off);
        if (idx.size() != 0) live_offsets.delete(idx[0]);
      end
    end
    pending_results.push_back(fixed ? typed : r);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  function automatic logic [FIELD_W-1:0] pick_size();
    int ord;
    if ($urandom_range(0, 3) != 0) ord = $urandom_range(0, 3);
    else ord = $urandom_range(0, DEF_MAX_ORDER);
    if (ord == 0) return FIELD_W'($urandom_range(0, BLOCK_BYTES - 1));
    return FIELD_W'($urandom_range((1 << (BLOCK_LOG2 + ord - 1)),
                                   (1 << (BLOCK_LOG2 + ord)) - 1));
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result beat %h with nothing pending", out_tdata));
      end else begin
        oldest = pending_results.pop_front();
        if (out_tdata[2:0] != oldest.status)
          report_mismatch($sformatf("status %0d, predicted %0d", out_tdata[2:0],
                                    oldest.status));
        if (out_tdata[25:3] != oldest.offset)
          report_mismatch($sformatf("block offset %0d, predicted %0d", out_tdata[25:3],
                                    oldest.offset));
      end
    end
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left--;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      out_tready <= 1'b0;
      hold_left = $urandom_range(0, 10);
    end else begin
      out_tready <= 1'b1;
    end
  end

  initial begin
    outcome_t         typed;
    cmd_t             cmd;
    logic [FIELD_W-1:0] req;
    logic [FIELD_W-1:0] off;
    int               pick;
    int               alloc_pct;
    clear_heap();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_steps[i]) begin
      typed.status = directed_steps[i].status;
      typed.offset = directed_steps[i].boff;
      issue_command(directed_steps[i].cmd, directed_steps[i].req, directed_steps[i].off,
                    directed_steps[i].fixed, typed);
    end

    typed = '0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS - QUIET_ITEMS) quiet = 1'b1;
      pick = $urandom_range(0, 99);
      req  = FIELD_W'($urandom);
      off  = FIELD_W'($urandom);
      if (pick < 4) begin
        cmd = CMD_ALLOC;
      end else if (pick < 8) begin
        cmd = CMD_FREE;
      end else if (pick < 14) begin
        // Aligned starts hit live blocks, free blocks and interior entries alike.
        cmd = CMD_FREE;
        off = FIELD_W'(($urandom_range(0, UNITS - 1) << BLOCK_LOG2) + 1);
      end else if (pick < 17) begin
        cmd = CMD_FREE;
        if (live_offsets.size() != 0)
          off = FIELD_W'(live_offsets[$urandom_range(0, live_offsets.size() - 1)] +
                         $urandom_range(1, BLOCK_BYTES - 1));
        else off = FIELD_W'($urandom_range(1, REGION_BYTES + 1));
      end else if (pick < 20) begin
        cmd = CMD_ALLOC;
        req = FIELD_W'($urandom_range(REGION_BYTES - 2, REGION_BYTES));
      end else begin
        if (live_offsets.size() < 8) alloc_pct = 80;
        else if (live_offsets.size() > 48) alloc_pct = 20;
        else alloc_pct = 50;
        if (live_offsets.size() == 0 || $urandom_range(0, 99) < alloc_pct) begin
          cmd = CMD_ALLOC;
          req = pick_size();
        end else begin
          cmd = CMD_FREE;
          off = FIELD_W'(live_offsets[$urandom_range(0, live_offsets.size() - 1)]);
        end
      end
      issue_command(cmd, req, off, 1'b0, typed);
    end

    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[buddy_block_allocator_unit] OK");
    end else begin
      $display("[buddy_block_allocator_unit] ERROR");
    end
    $finish;
  end

  initial begin
    #160000000;
    $display("[buddy_block_allocator_unit] ERROR");
    $finish;
  end

endmodule

`default_nettype wire

### files.f
rtl/core/bba_pkg.sv
rtl/core/bba_ram.sv
rtl/core/buddy_block_allocator_unit.sv
tb/tb_buddy_block_allocator_unit.sv
